FILE: src/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_CLK(lbl, clk, rst_n, !(cond))

`endif

FILE: src/ttbm_pkg.sv
`default_nettype none

package ttbm_pkg;

  localparam logic [4:0] VolMax      = 5'd20;
  localparam logic [4:0] VolReset    = 5'd10;
  localparam logic [7:0] PeriodReset = 8'd6;

  typedef enum logic [2:0] {
    CmdPlayBoth = 3'd0,
    CmdPlayOne  = 3'd1,
    CmdPlayTwo  = 3'd2,
    CmdStop     = 3'd3,
    CmdTick     = 3'd4,
    CmdSetVol   = 3'd5,
    CmdVolUp    = 3'd6,
    CmdVolDown  = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] first_freq;
    logic [15:0] second_freq;
    logic [15:0] tone_freq;
    logic [7:0]  new_volume;
  } in_item_t;

  typedef struct packed {
    logic        freq_written;
    logic [15:0] pwm_freq;
    logic [9:0]  pwm_duty;
  } out_item_t;

  typedef struct packed {
    logic      vld;
    out_item_t data;
  } result_t;

  // Duty per volume step: exponential, linear past 16.
  function automatic logic [9:0] duty_of(logic [4:0] vol);
    logic [9:0] d;
    case (vol)
      5'd0:    d = 10'd0;
      5'd1:    d = 10'd1;
      5'd2:    d = 10'd2;
      5'd3:    d = 10'd3;
      5'd4:    d = 10'd4;
      5'd5:    d = 10'd6;
      5'd6:    d = 10'd8;
      5'd7:    d = 10'd12;
      5'd8:    d = 10'd16;
      5'd9:    d = 10'd24;
      5'd10:   d = 10'd32;
      5'd11:   d = 10'd48;
      5'd12:   d = 10'd64;
      5'd13:   d = 10'd96;
      5'd14:   d = 10'd128;
      5'd15:   d = 10'd192;
      5'd16:   d = 10'd256;
      5'd17:   d = 10'd320;
      5'd18:   d = 10'd384;
      5'd19:   d = 10'd448;
      default: d = 10'd512;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: src/ttbm_engine.sv
`default_nettype none
`include "assert_macros.svh"

module ttbm_engine (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                go_i,
  input  wire ttbm_pkg::in_item_t  item_i,
  input  wire logic [7:0]          period_i,
  output ttbm_pkg::result_t        res_o
);

  logic [15:0] c1_q, c1_d;
  logic [15:0] c2_q, c2_d;
  logic        flag_q, flag_d;
  logic [15:0] ms_q, ms_d;
  logic [4:0]  vol_q, vol_d;

  logic [15:0] ms_inc;
  logic        emit;
  logic [15:0] emit_f;
  logic        vol_cmd;
  logic        vol_hit;
  ttbm_pkg::cmd_e cmd;

  assign cmd    = ttbm_pkg::cmd_e'(item_i.command);
  assign ms_inc = (ms_q == 16'hFFFF) ? ms_q : ms_q + 16'd1;

  always_comb begin
    c1_d    = c1_q;
    c2_d    = c2_q;
    flag_d  = flag_q;
    ms_d    = ms_q;
    vol_d   = vol_q;
    emit    = 1'b0;
    emit_f  = 16'd0;
    vol_cmd = 1'b0;
    unique case (cmd)
      ttbm_pkg::CmdPlayBoth: begin
        c1_d   = item_i.first_freq;
        c2_d   = item_i.second_freq;
        emit   = 1'b1;
        emit_f = (item_i.first_freq != 16'd0) ? item_i.first_freq : item_i.second_freq;
      end
      ttbm_pkg::CmdPlayOne: begin
        c1_d = item_i.tone_freq;
        if (item_i.tone_freq != 16'd0) begin
          emit   = 1'b1;
          emit_f = item_i.tone_freq;
        end else if (c2_q == 16'd0) begin
          emit = 1'b1;
        end
      end
      ttbm_pkg::CmdPlayTwo: begin
        c2_d = item_i.tone_freq;
        if (c1_q == 16'd0) begin
          emit   = 1'b1;
          emit_f = item_i.tone_freq;
        end
      end
      ttbm_pkg::CmdStop: begin
        c1_d = 16'd0;
        c2_d = 16'd0;
        emit = 1'b1;
      end
      ttbm_pkg::CmdTick: begin
        ms_d = ms_inc;
        if (c1_q == 16'd0 && c2_q == 16'd0) begin
          emit = 1'b0;
        end else if (c2_q == 16'd0) begin
          if (flag_q) begin
            flag_d = 1'b0;
            emit   = 1'b1;
            emit_f = c1_q;
          end
        end else if (c1_q == 16'd0) begin
          if (!flag_q) begin
            flag_d = 1'b1;
            emit   = 1'b1;
            emit_f = c2_q;
          end
        end else if (ms_inc >= {8'd0, period_i}) begin
          ms_d   = 16'd0;
          flag_d = ~flag_q;
          emit   = 1'b1;
          emit_f = flag_q ? c2_q : c1_q;
        end
      end
      ttbm_pkg::CmdSetVol: begin
        vol_cmd = 1'b1;
        vol_d   = (item_i.new_volume > {3'd0, ttbm_pkg::VolMax}) ?
                  ttbm_pkg::VolMax : item_i.new_volume[4:0];
      end
      ttbm_pkg::CmdVolUp: begin
        vol_cmd = (vol_q < ttbm_pkg::VolMax);
        if (vol_cmd) vol_d = vol_q + 5'd1;
      end
      ttbm_pkg::CmdVolDown: begin
        vol_cmd = (vol_q != 5'd0);
        if (vol_cmd) vol_d = vol_q - 5'd1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    // A volume change replays c1_q if flag_q or c1_q, else c2_q.
    vol_hit = vol_cmd && (c1_q != 16'd0 || c2_q != 16'd0);
    if (vol_hit) begin
      emit   = 1'b1;
      emit_f = (flag_q || c1_q != 16'd0) ? c1_q : c2_q;
    end
  end

  always_comb begin
    res_o.vld = emit;
    if (emit_f == 16'd0 || vol_d == 5'd0) begin
      res_o.data.freq_written = 1'b0;
      res_o.data.pwm_freq     = 16'd0;
      res_o.data.pwm_duty     = 10'd0;
    end else begin
      res_o.data.freq_written = 1'b1;
      res_o.data.pwm_freq     = emit_f;
      res_o.data.pwm_duty     = ttbm_pkg::duty_of(vol_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q   <= 16'd0;
      c2_q   <= 16'd0;
      flag_q <= 1'b0;
      ms_q   <= 16'd0;
      vol_q  <= ttbm_pkg::VolReset;
    end else if (go_i) begin
      c1_q   <= c1_d;
      c2_q   <= c2_d;
      flag_q <= flag_d;
      ms_q   <= ms_d;
      vol_q  <= vol_d;
    end
  end

  `ASSERT_NEVER(a_vol_range, clk_i, rst_ni, vol_q > ttbm_pkg::VolMax)
  `ASSERT_CLK(a_mute_zero, clk_i, rst_ni,
    res_o.vld && !res_o.data.freq_written |->
      res_o.data.pwm_freq == 16'd0 && res_o.data.pwm_duty == 10'd0)
  `ASSERT_CLK(a_flag_on_tick, clk_i, rst_ni,
    !$stable(flag_q) |-> $past(go_i) && $past(item_i.command) == ttbm_pkg::CmdTick)

endmodule

`default_nettype wire

FILE: src/two_tone_buzzer_multiplexer.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   in_data_i   (ttbm_pkg::in_item_t)
// out       output     out_valid_o/out_ready_i out_data_o  (ttbm_pkg::out_item_t)
// cfg       input      cfg_we_i                cfg_wdata_i (mux period in ms)
//
// One item per cycle sustained while the output is not stalled; an item passes
// the input register, then the command engine, then the result register.
// Reset: volume 10, period 6 ms, both channels silent, mux flag and counter 0.
// A stalled output holds its result; the input register keeps its item until
// the result register frees up, and only items that give no result bypass.
// Configuration writes go into the period register and are never stalled.
`default_nettype none
`include "assert_macros.svh"

module two_tone_buzzer_multiplexer (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire ttbm_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output ttbm_pkg::out_item_t       out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [7:0]           cfg_wdata_i
);

  // Mux period register.
  logic [7:0] period_q;

  // Input stage.
  logic               item_vld_q;
  ttbm_pkg::in_item_t item_q;

  // Result stage.
  logic                out_vld_q;
  ttbm_pkg::out_item_t out_q;

  ttbm_pkg::result_t res;
  logic              out_free;
  logic              s1_go;
  logic              in_take;

  // The result register is free when empty or being drained this cycle.
  assign out_free = !out_vld_q || out_ready_i;
  // Advance the input stage when its result (if any) has somewhere to go.
  assign s1_go    = item_vld_q && (!res.vld || out_free);
  assign in_ready_o = !item_vld_q || s1_go;
  assign in_take    = in_valid_i && in_ready_o;

  ttbm_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (s1_go),
    .item_i   (item_q),
    .period_i (period_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= ttbm_pkg::PeriodReset;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  // Payload register: load on accept only.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_go && res.vld) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && res.vld) begin
      out_q <= res.data;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `ASSERT_CLK(a_out_from_stage, clk_i, rst_ni, $rose(out_valid_o) |-> $past(item_vld_q))
  `ASSERT_CLK(a_stage_holds, clk_i, rst_ni, item_vld_q && !in_ready_o |=> item_vld_q)
  `ASSERT_CLK(a_empty_ready, clk_i, rst_ni, !item_vld_q |-> in_ready_o)

endmodule

`default_nettype wire
